// ===== sv/sal_pkg.sv =====
// Package for the sorted slot-linked list: field widths, request and status codes,
// and the signed key compare. No dependencies.
package sal_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int SLOTS_DEF = 64;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef logic signed [KEY_W-1:0] t_key;

    function automatic logic key_less(input t_key a, input t_key b);
        return a < b;
    endfunction

endpackage

// ===== sv/sal_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on sal_pkg.
interface sal_req_if import sal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    t_key                key;

    modport source(output valid, output op, output key, input ready);
    modport sink(input valid, input op, input key, output ready);
endinterface

interface sal_rsp_if import sal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;

    modport source(output valid, output status, output slot, output count, input ready);
    modport sink(input valid, input status, input slot, input count, output ready);
endinterface

// ===== sv/sorted_array_linked_list.sv =====
// Flow: clear and an insert into a full list go straight to the result register; search,
// delete and insert walk the list past each key below the request key, one link memory
// read per step (up to SLOTS keys), and insert first reads the free list head.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; empty list, all slots free. No clearing pass: slots
// at or above the fill mark read as chained in order. Depends on sal_pkg and sal_if.
module sorted_array_linked_list import sal_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sal_req_if.sink    i_req,
    sal_rsp_if.source  o_rsp
);

    localparam int LW = $clog2(SLOTS + 1);
    localparam int SW = $clog2(SLOTS);

    typedef logic [LW-1:0] t_link;
    typedef logic [SW-1:0] t_addr;

    localparam t_link LINK_NONE = t_link'(SLOTS);
    localparam t_link LINK_FULL = t_link'(SLOTS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FREE    = 3'd1;
    localparam logic [2:0] S_WALK    = 3'd2;
    localparam logic [2:0] S_RESOLVE = 3'd3;
    localparam logic [2:0] S_LINK    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    // slot store
    t_key  r_keys  [SLOTS];
    t_link r_links [SLOTS];
    t_key  r_rd_key;
    t_link r_rd_link;
    t_addr r_rd_addr;

    logic [2:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    t_key                r_key, n_key;
    t_link               r_cur, n_cur;
    t_link               r_prev, n_prev;
    t_link               r_list_head, n_list_head;
    t_link               r_free_head, n_free_head;
    t_link               r_free_next, n_free_next;
    t_link               r_count, n_count;
    t_link               r_fill, n_fill;
    t_link               r_link_data, n_link_data;
    logic [STATUS_W-1:0] r_status, n_status;
    t_link               r_slot, n_slot;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic  rd_en;
    t_addr rd_addr;
    logic  wr_key_en;
    logic  wr_link_en;
    t_addr wr_addr;
    t_link wr_link;
    t_link rd_next;
    logic  found;

    // link of a slot; slots never allocated since clear or reset chain to the next index, the last slot to none
    function automatic t_link link_of(input t_addr a, input t_link d, input t_link fill);
        if (t_link'(a) >= fill) begin
            return (a == t_addr'(SLOTS - 1)) ? LINK_NONE : t_link'(t_link'(a) + 1'b1);
        end
        return d;
    endfunction

    assign rd_next = link_of(r_rd_addr, r_rd_link, r_fill);
    assign found   = (r_cur != LINK_NONE) && (r_rd_key == r_key);

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;
    assign o_rsp.count  = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_list_head  = r_list_head;
        n_free_head  = r_free_head;
        n_free_next  = r_free_next;
        n_count      = r_count;
        n_fill       = r_fill;
        n_link_data  = r_link_data;
        n_status     = r_status;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_count  = r_out_count;
        rd_en        = 1'b0;
        rd_addr      = r_free_head[SW-1:0];
        wr_key_en    = 1'b0;
        wr_link_en   = 1'b0;
        wr_addr      = r_prev[SW-1:0];
        wr_link      = r_link_data;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.op;
                    n_key    = i_req.key;
                    n_status = ST_OK;
                    n_slot   = '0;
                    case (i_req.op)
                        OP_CLEAR: begin
                            n_list_head = LINK_NONE;
                            n_free_head = '0;
                            n_count     = '0;
                            n_fill      = '0;
                            n_state     = S_DONE;
                        end
                        OP_INSERT: begin
                            if (r_free_head == LINK_NONE) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_free_head[SW-1:0];
                                n_state = S_FREE;
                            end
                        end
                        default: begin
                            n_prev = LINK_NONE;
                            n_cur  = r_list_head;
                            if (r_list_head == LINK_NONE) begin
                                n_state = S_RESOLVE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_list_head[SW-1:0];
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_FREE: begin
                n_free_next = rd_next;
                n_prev      = LINK_NONE;
                n_cur       = r_list_head;
                if (r_list_head == LINK_NONE) begin
                    n_state = S_RESOLVE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_list_head[SW-1:0];
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (key_less(r_rd_key, r_key)) begin
                    n_prev = r_cur;
                    n_cur  = rd_next;
                    if (rd_next == LINK_NONE) begin
                        n_state = S_RESOLVE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = rd_next[SW-1:0];
                    end
                end else begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_state = S_DONE;
                case (r_op)
                    OP_INSERT: begin
                        if (found) begin
                            n_status = ST_DUP;
                        end else begin
                            wr_key_en   = 1'b1;
                            wr_link_en  = 1'b1;
                            wr_addr     = r_free_head[SW-1:0];
                            wr_link     = r_cur;
                            n_free_head = r_free_next;
                            if (r_free_head >= r_fill) begin
                                n_fill = t_link'(r_free_head + 1'b1);
                            end
                            n_count     = t_link'(r_count + 1'b1);
                            n_slot      = r_free_head;
                            n_link_data = r_free_head;
                            if (r_prev == LINK_NONE) begin
                                n_list_head = r_free_head;
                            end else begin
                                n_state = S_LINK;
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (!found) begin
                            n_status = ST_NOTFOUND;
                        end else begin
                            wr_link_en  = 1'b1;
                            wr_addr     = r_cur[SW-1:0];
                            wr_link     = r_free_head;
                            n_free_head = r_cur;
                            if (r_count != '0) begin
                                n_count = t_link'(r_count - 1'b1);
                            end
                            n_link_data = rd_next;
                            if (r_prev == LINK_NONE) begin
                                n_list_head = rd_next;
                            end else begin
                                n_state = S_LINK;
                            end
                        end
                    end
                    default: begin
                        if (found) begin
                            n_slot = r_cur;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                endcase
            end
            S_LINK: begin
                wr_link_en = 1'b1;
                wr_addr    = r_prev[SW-1:0];
                wr_link    = r_link_data;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_slot   = SLOT_W'(r_slot);
                    n_out_count  = COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_key_en) begin
            r_keys[wr_addr] <= r_key;
        end
        if (wr_link_en) begin
            r_links[wr_addr] <= wr_link;
        end
        if (rd_en) begin
            r_rd_key  <= r_keys[rd_addr];
            r_rd_link <= r_links[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_list_head <= LINK_NONE;
            r_free_head <= '0;
            r_count     <= '0;
            r_fill      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_count     <= n_count;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_free_next  <= n_free_next;
        r_link_data  <= n_link_data;
        r_status     <= n_status;
        r_slot       <= n_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_count  <= n_out_count;
    end

`ifndef NO_ASSERTIONS
    a_free_empty_iff_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head == LINK_NONE) == (r_count == LINK_FULL))
        else $error("free list state disagrees with entry count");

    a_count_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= r_fill) && (r_fill <= LINK_FULL))
        else $error("entry count exceeds fill mark");

    a_walk_on_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur != LINK_NONE) && $past(rd_en))
        else $error("walk step without a pending slot read");

    a_link_after_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> (r_prev != LINK_NONE) && ($past(r_state) == S_RESOLVE))
        else $error("predecessor relink without predecessor");
`endif

endmodule
